// ===== src/tct_pkg.sv =====
// Shared types and constants for the touch contact tracker.
// Holds the request and result structs, state and kind codes, and register indexes.
// No dependencies.
package tct_pkg;

  // Widths.
  localparam int COORD_BITS = 12;
  localparam int ID_BITS    = 8;
  localparam int TAG_BITS   = 4;
  localparam int KIND_BITS  = 3;
  localparam int EVENT_BITS = 2;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = COORD_BITS;
  localparam int STATE_BITS = 2;

  // A reference with the top bit set is invalid and lies above every reading.
  localparam logic [COORD_BITS:0] REF_INVALID = {1'b1, {COORD_BITS{1'b0}}};

  // Low tag bits that flag a bad conversion.
  localparam logic [TAG_BITS-1:0] TAG_BAD_MASK = 4'h3;

  // Reset thresholds.
  localparam logic [COORD_BITS-1:0] THRESHOLD_RESET = COORD_BITS'(12);

  // Request types.
  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  // Contact states.
  localparam logic [STATE_BITS-1:0] ST_NONE = 2'd0;
  localparam logic [STATE_BITS-1:0] ST_DOWN = 2'd1;
  localparam logic [STATE_BITS-1:0] ST_MOVE = 2'd2;
  localparam logic [STATE_BITS-1:0] ST_UP   = 2'd3;

  // Result kinds.
  localparam logic [KIND_BITS-1:0] KIND_IGNORED  = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_POSTED   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_DEFERRED = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_REPORT   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_NODATA   = 3'd4;

  // Report events.
  localparam logic [EVENT_BITS-1:0] EV_UP   = 2'd0;
  localparam logic [EVENT_BITS-1:0] EV_DOWN = 2'd1;
  localparam logic [EVENT_BITS-1:0] EV_MOVE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] CFG_THRESHOLD_X = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_THRESHOLD_Y = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SWAP_AXES   = 2'd2;

  typedef struct packed {
    logic                  req_type;
    logic                  pen_down;
    logic [COORD_BITS-1:0] x_reading;
    logic [COORD_BITS-1:0] y_reading;
    logic [TAG_BITS-1:0]   x_tag;
  } tct_req_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  result_kind;
    logic                  rearm_timer;
    logic [EVENT_BITS-1:0] touch_event;
    logic                  position_valid;
    logic [ID_BITS-1:0]    touch_id;
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
  } tct_res_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] threshold_x;
    logic [COORD_BITS-1:0] threshold_y;
    logic                  swap_axes;
  } tct_cfg_t;

endpackage

// ===== src/tct_cfg_regs.sv =====
// Configuration registers of the touch contact tracker.
// Depends on tct_pkg for the register indexes and the config struct.
module tct_cfg_regs import tct_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output tct_cfg_t                 cfg
);

  tct_cfg_t cfg_r;

  // Register writes; an index outside the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_x <= THRESHOLD_RESET;
      cfg_r.threshold_y <= THRESHOLD_RESET;
      cfg_r.swap_axes   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_THRESHOLD_X: cfg_r.threshold_x <= cfg_wdata[COORD_BITS-1:0];
        CFG_THRESHOLD_Y: cfg_r.threshold_y <= cfg_wdata[COORD_BITS-1:0];
        CFG_SWAP_AXES:   cfg_r.swap_axes   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tct_core.sv =====
// Contact state and combinational request handling of the touch contact tracker.
// Depends on tct_pkg for the structs, state codes and result kinds.
module tct_core import tct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  tct_req_t req,
  input  tct_cfg_t cfg,
  output tct_res_t res
);

  logic [COORD_BITS:0]   ref_x_r, ref_x_nxt;
  logic [COORD_BITS:0]   ref_y_r, ref_y_nxt;
  logic [STATE_BITS-1:0] contact_state_r, contact_state_nxt;
  logic [COORD_BITS-1:0] held_x_r, held_x_nxt;
  logic [COORD_BITS-1:0] held_y_r, held_y_nxt;
  logic                  held_valid_r, held_valid_nxt;
  logic [ID_BITS-1:0]    next_id_r, next_id_nxt;
  logic [ID_BITS-1:0]    held_id_r, held_id_nxt;
  logic                  report_pending_r, report_pending_nxt;

  logic [COORD_BITS-1:0] pos_x, pos_y;
  logic [COORD_BITS:0]   ext_x, ext_y;
  logic [COORD_BITS:0]   dist_x, dist_y;
  logic                  in_deadband;
  logic                  tag_bad;

  // Axis swap and distance from the deadband reference.
  assign pos_x  = cfg.swap_axes ? req.y_reading : req.x_reading;
  assign pos_y  = cfg.swap_axes ? req.x_reading : req.y_reading;
  assign ext_x  = {1'b0, pos_x};
  assign ext_y  = {1'b0, pos_y};
  assign dist_x = (ext_x > ref_x_r) ? ext_x - ref_x_r : ref_x_r - ext_x;
  assign dist_y = (ext_y > ref_y_r) ? ext_y - ref_y_r : ref_y_r - ext_y;
  assign in_deadband = (dist_x < {1'b0, cfg.threshold_x}) &&
                       (dist_y < {1'b0, cfg.threshold_y});
  assign tag_bad = (req.x_tag & TAG_BAD_MASK) != '0;

  // Next state and result for the request in hand.
  always_comb begin
    ref_x_nxt          = ref_x_r;
    ref_y_nxt          = ref_y_r;
    contact_state_nxt  = contact_state_r;
    held_x_nxt         = held_x_r;
    held_y_nxt         = held_y_r;
    held_valid_nxt     = held_valid_r;
    next_id_nxt        = next_id_r;
    held_id_nxt        = held_id_r;
    report_pending_nxt = report_pending_r;
    res                = '0;
    res.result_kind    = KIND_IGNORED;

    if (req.req_type == REQ_MEASURE) begin
      priority if (!req.pen_down) begin
        // Pen lifted: drop the reference and post an up if a contact was live.
        ref_x_nxt = REF_INVALID;
        ref_y_nxt = REF_INVALID;
        if (contact_state_r == ST_DOWN || contact_state_r == ST_MOVE) begin
          contact_state_nxt  = ST_UP;
          held_id_nxt        = next_id_r;
          report_pending_nxt = 1'b1;
          res.result_kind    = KIND_POSTED;
        end
      end else if (contact_state_r == ST_UP) begin
        // An unread up must not be overwritten by a new touch.
        res.result_kind = KIND_DEFERRED;
        res.rearm_timer = 1'b1;
      end else if (tag_bad || in_deadband) begin
        res.rearm_timer = 1'b1;
      end else begin
        ref_x_nxt          = ext_x;
        ref_y_nxt          = ext_y;
        held_x_nxt         = pos_x;
        held_y_nxt         = pos_y;
        held_valid_nxt     = 1'b1;
        held_id_nxt        = next_id_r;
        report_pending_nxt = 1'b1;
        if (contact_state_r != ST_MOVE) begin
          contact_state_nxt = ST_DOWN;
        end
        res.result_kind = KIND_POSTED;
        res.rearm_timer = 1'b1;
      end
    end else if (!report_pending_r) begin
      res.result_kind = KIND_NODATA;
    end else begin
      // Hand out the held report and advance the contact.
      res.result_kind    = KIND_REPORT;
      res.touch_id       = held_id_r;
      res.x_pos          = held_x_r;
      res.y_pos          = held_y_r;
      report_pending_nxt = 1'b0;
      unique case (contact_state_r)
        ST_UP: begin
          res.touch_event    = EV_UP;
          res.position_valid = held_valid_r;
          contact_state_nxt  = ST_NONE;
          held_valid_nxt     = 1'b0;
          next_id_nxt        = next_id_r + ID_BITS'(1);
        end
        ST_DOWN: begin
          res.touch_event    = EV_DOWN;
          res.position_valid = 1'b1;
          contact_state_nxt  = ST_MOVE;
        end
        ST_MOVE, ST_NONE: begin
          res.touch_event    = EV_MOVE;
          res.position_valid = 1'b1;
        end
      endcase
    end
  end

  // State registers advance only when a request is handled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r          <= REF_INVALID;
      ref_y_r          <= REF_INVALID;
      contact_state_r  <= ST_NONE;
      held_x_r         <= '0;
      held_y_r         <= '0;
      held_valid_r     <= 1'b0;
      next_id_r        <= '0;
      held_id_r        <= '0;
      report_pending_r <= 1'b0;
    end else if (go) begin
      ref_x_r          <= ref_x_nxt;
      ref_y_r          <= ref_y_nxt;
      contact_state_r  <= contact_state_nxt;
      held_x_r         <= held_x_nxt;
      held_y_r         <= held_y_nxt;
      held_valid_r     <= held_valid_nxt;
      next_id_r        <= next_id_nxt;
      held_id_r        <= held_id_nxt;
      report_pending_r <= report_pending_nxt;
    end
  end

endmodule

// ===== src/touch_contact_tracker.sv =====
// Channel   Direction  Payload    Handshake
// in_       input      tct_req_t  in_valid / in_stall
// out_      output     tct_res_t  out_valid / out_stall
// cfg_      input      index+data cfg_we, no wait
//
// Each request is registered, handled against the contact state, and its result
// registered: out_valid rises when the request moves on into the result register.
// One request per cycle is sustained while out_stall is low; the input and result registers form the path.
// Reset clears both stages, the contact state and the configuration at once.
// A stalled result holds the result register and, behind it, the input register.
// Depends on tct_pkg, tct_cfg_regs and tct_core.
module touch_contact_tracker import tct_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  tct_req_t                 in_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output tct_res_t                 out_res,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  tct_cfg_t cfg;
  tct_req_t req_r;
  logic     req_valid_r;
  tct_res_t res;
  tct_res_t res_r;
  logic     res_valid_r;
  logic     res_free;
  logic     advance;
  logic     in_take;

  tct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tct_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (advance),
    .req   (req_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Pipeline flow: the held request moves on when the result register is free.
  assign res_free = !res_valid_r || !out_stall;
  assign advance  = req_valid_r && res_free;
  assign in_stall = req_valid_r && !res_free;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= in_take || (req_valid_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_req;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = res_valid_r;
  assign out_res   = res_r;

endmodule

// ===== src/tct_checker.sv =====
// Port-level checks for the touch contact tracker, bound to the top level.
// Depends on tct_pkg for the result struct and the kind and event codes.
module tct_checker import tct_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input tct_res_t out_res
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  // No result shows in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Only reports carry payload fields.
  a_quiet_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.result_kind != KIND_REPORT |->
      out_res.touch_event == EV_UP && !out_res.position_valid &&
      out_res.touch_id == '0 && out_res.x_pos == '0 && out_res.y_pos == '0)
    else $error("payload set on a non-report result");

  // Reads never rearm the timer; deferrals always do.
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_res.result_kind == KIND_REPORT || out_res.result_kind == KIND_NODATA)
         ? !out_res.rearm_timer
         : (out_res.result_kind != KIND_DEFERRED || out_res.rearm_timer)))
    else $error("rearm flag inconsistent with result kind");

  // Kinds and events stay within their codes.
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.result_kind <= KIND_NODATA && out_res.touch_event <= EV_MOVE)
    else $error("result code out of range");

endmodule

bind touch_contact_tracker tct_checker u_tct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the touch contact tracker.
// Depends on tct_pkg and touch_contact_tracker; predicts every result in SystemVerilog.
module tb;
  import tct_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_AT_RESULT = 400;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_PRINTS = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tct_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tct_res_t out_res;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // Requests waiting to be offered and results waiting to be seen.
  tct_req_t touch_reqs_q[$];
  tct_res_t touch_results_q[$];

  // Predicted configuration and contact state.
  logic [COORD_BITS-1:0] m_thr_x = THRESHOLD_RESET;
  logic [COORD_BITS-1:0] m_thr_y = THRESHOLD_RESET;
  logic m_swap = 1'b0;
  logic [COORD_BITS:0] m_ref_x = REF_INVALID;
  logic [COORD_BITS:0] m_ref_y = REF_INVALID;
  logic [STATE_BITS-1:0] m_contact = ST_NONE;
  logic [COORD_BITS-1:0] m_held_x = '0;
  logic [COORD_BITS-1:0] m_held_y = '0;
  logic m_held_valid = 1'b0;
  logic [ID_BITS-1:0] m_next_id = '0;
  logic [ID_BITS-1:0] m_held_id = '0;
  logic m_pending = 1'b0;

  logic idle_on = 1'b1;
  int mismatch_count = 0;
  int results_seen = 0;
  int cycles = 0;
  int drv_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int walk_span = 30;
  int items_pushed = 0;

  touch_contact_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Works out the result of one request and advances the predicted contact state.
  function automatic tct_res_t track_touch(tct_req_t r);
    tct_res_t res;
    logic [COORD_BITS-1:0] px, py;
    logic [COORD_BITS:0] dx, dy;
    logic post;
    res = '0;
    post = 1'b0;
    if (r.req_type == REQ_MEASURE) begin
      px = m_swap ? r.y_reading : r.x_reading;
      py = m_swap ? r.x_reading : r.y_reading;
      if (!r.pen_down) begin
        m_ref_x = REF_INVALID;
        m_ref_y = REF_INVALID;
        if (m_contact == ST_NONE || m_contact == ST_UP) begin
          res.result_kind = KIND_IGNORED;
        end else begin
          m_contact = ST_UP;
          post = 1'b1;
        end
      end else if (m_contact == ST_UP) begin
        res.result_kind = KIND_DEFERRED;
        res.rearm_timer = 1'b1;
      end else begin
        res.rearm_timer = 1'b1;
        dx = ({1'b0, px} > m_ref_x) ? {1'b0, px} - m_ref_x : m_ref_x - {1'b0, px};
        dy = ({1'b0, py} > m_ref_y) ? {1'b0, py} - m_ref_y : m_ref_y - {1'b0, py};
        if ((r.x_tag & TAG_BAD_MASK) != '0) begin
          res.result_kind = KIND_IGNORED;
        end else if (dx < {1'b0, m_thr_x} && dy < {1'b0, m_thr_y}) begin
          res.result_kind = KIND_IGNORED;
        end else begin
          m_ref_x = {1'b0, px};
          m_ref_y = {1'b0, py};
          m_held_x = px;
          m_held_y = py;
          m_held_valid = 1'b1;
          if (m_contact != ST_MOVE) m_contact = ST_DOWN;
          post = 1'b1;
        end
      end
      if (post) begin
        m_held_id = m_next_id;
        m_pending = 1'b1;
        res.result_kind = KIND_POSTED;
      end
    end else if (!m_pending) begin
      res.result_kind = KIND_NODATA;
    end else begin
      res.result_kind = KIND_REPORT;
      res.touch_id = m_held_id;
      res.x_pos = m_held_x;
      res.y_pos = m_held_y;
      if (m_contact == ST_UP) begin
        res.touch_event = EV_UP;
        res.position_valid = m_held_valid;
        m_contact = ST_NONE;
        m_held_valid = 1'b0;
        m_next_id = m_next_id + 1'b1;
      end else if (m_contact == ST_DOWN) begin
        res.touch_event = EV_DOWN;
        res.position_valid = 1'b1;
        m_contact = ST_MOVE;
      end else begin
        res.touch_event = EV_MOVE;
        res.position_valid = 1'b1;
      end
      m_pending = 1'b0;
    end
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatch_count++;
  endtask

  // Compares one result from the block with the oldest prediction.
  task automatic check_result(tct_res_t got);
    tct_res_t want;
    if (touch_results_q.size() == 0) begin
      flag_mismatch($sformatf("result %h with nothing predicted", got));
      return;
    end
    want = touch_results_q.pop_front();
    if (got.result_kind != want.result_kind)
      flag_mismatch($sformatf("result_kind %0d, want %0d", got.result_kind, want.result_kind));
    if (got.rearm_timer != want.rearm_timer)
      flag_mismatch($sformatf("rearm_timer %0d, want %0d", got.rearm_timer, want.rearm_timer));
    if (got.touch_event != want.touch_event)
      flag_mismatch($sformatf("touch_event %0d, want %0d", got.touch_event, want.touch_event));
    if (got.position_valid != want.position_valid)
      flag_mismatch($sformatf("position_valid %0d, want %0d", got.position_valid,
                              want.position_valid));
    if (got.touch_id != want.touch_id)
      flag_mismatch($sformatf("touch_id %0d, want %0d", got.touch_id, want.touch_id));
    if (got.x_pos != want.x_pos)
      flag_mismatch($sformatf("x_pos %0d, want %0d", got.x_pos, want.x_pos));
    if (got.y_pos != want.y_pos)
      flag_mismatch($sformatf("y_pos %0d, want %0d", got.y_pos, want.y_pos));
  endtask

  // Driver: offers queued requests, with random gaps, and predicts each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid && !in_stall) touch_results_q.push_back(track_touch(in_req));
      if (!(in_valid && in_stall)) begin
        if (drv_gap != 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          drv_gap = $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else if (touch_reqs_q.size() != 0) begin
          in_valid <= 1'b1;
          in_req <= touch_reqs_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted results and stalls the block at random.
  // Once, it holds off long enough for the pipeline to fill and stall the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_res);
        results_seen++;
        if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_req(logic rt, logic pen, logic [COORD_BITS-1:0] x,
                          logic [COORD_BITS-1:0] y, logic [TAG_BITS-1:0] tag);
    tct_req_t r;
    r.req_type = rt;
    r.pen_down = pen;
    r.x_reading = x;
    r.y_reading = y;
    r.x_tag = tag;
    touch_reqs_q.push_back(r);
    items_pushed++;
  endtask

  // Writes one register; the block must be idle.
  task automatic write_cfg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_THRESHOLD_X: m_thr_x = data;
      CFG_THRESHOLD_Y: m_thr_y = data;
      CFG_SWAP_AXES:   m_swap = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cfg(int thr_x, int thr_y, int swap);
    write_cfg(CFG_THRESHOLD_X, CFG_DATA_BITS'(thr_x));
    write_cfg(CFG_THRESHOLD_Y, CFG_DATA_BITS'(thr_y));
    write_cfg(CFG_SWAP_AXES, CFG_DATA_BITS'(swap));
  endtask

  // Waits until every request is accepted and every result checked.
  // Sampled on the falling edge so that all clocked updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (touch_reqs_q.size() != 0 || in_valid || touch_results_q.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  // Moves a coordinate by a small step, now and then by a jump across the panel.
  function automatic logic [COORD_BITS-1:0] walk(logic [COORD_BITS-1:0] c);
    int step, v;
    step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, walk_span);
    v = $urandom_range(0, 1) ? int'(c) + step : int'(c) - step;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return COORD_BITS'(v);
  endfunction

  // One contact from pen down to pen up, with reads in between and after.
  task automatic push_gesture();
    logic [COORD_BITS-1:0] cx, cy;
    logic [TAG_BITS-1:0] tag;
    int moves;
    cx = COORD_BITS'($urandom_range(0, 4095));
    cy = COORD_BITS'($urandom_range(0, 4095));
    moves = $urandom_range(1, 10);
    for (int k = 0; k < moves; k++) begin
      if ($urandom_range(0, 7) == 0) tag = TAG_BITS'($urandom_range(0, 15));
      else tag = {2'($urandom_range(0, 3)), 2'b00};
      push_req(REQ_MEASURE, 1'b1, cx, cy, tag);
      if ($urandom_range(0, 2) == 0) push_req(REQ_READ, 1'b0, '0, '0, '0);
      cx = walk(cx);
      cy = walk(cy);
    end
    push_req(REQ_MEASURE, 1'b0, cx, cy, TAG_BITS'($urandom_range(0, 15)));
    // A pen-down or a second pen-up may land before the up is read.
    if ($urandom_range(0, 2) == 0)
      push_req(REQ_MEASURE, 1'($urandom_range(0, 1)), walk(cx), walk(cy), '0);
    if ($urandom_range(0, 5) != 0) push_req(REQ_READ, 1'b0, '0, '0, '0);
    if ($urandom_range(0, 3) == 0) push_req(REQ_READ, 1'b0, '0, '0, '0);
  endtask

  // Mostly whole gestures, the rest arbitrary requests.
  task automatic fill_random(int n_items);
    int target;
    target = items_pushed + n_items;
    while (items_pushed < target) begin
      if ($urandom_range(0, 5) != 0) begin
        push_gesture();
      end else begin
        push_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 COORD_BITS'($urandom_range(0, 4095)), COORD_BITS'($urandom_range(0, 4095)),
                 TAG_BITS'($urandom_range(0, 15)));
      end
    end
  endtask

  // Stimulus sequence: reset, directed cases, then random phases under several settings.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_cfg(12, 12, 0);
    // Directed: reads with nothing pending, bad tags, deadband, overwrite,
    // pen-down while up, pen-up while up, and id increment.
    push_req(REQ_READ, 1'b0, '0, '0, '0);
    push_req(REQ_MEASURE, 1'b0, 12'd7, 12'd9, 4'h0);
    push_req(REQ_MEASURE, 1'b1, 12'd50, 12'd50, 4'h1);
    push_req(REQ_MEASURE, 1'b1, 12'd50, 12'd50, 4'h2);
    push_req(REQ_MEASURE, 1'b1, 12'd0, 12'd0, 4'h0);
    push_req(REQ_MEASURE, 1'b1, 12'd5, 12'd11, 4'h0);
    push_req(REQ_READ, 1'b0, '0, '0, '0);
    push_req(REQ_MEASURE, 1'b1, 12'd4095, 12'd4095, 4'hC);
    push_req(REQ_READ, 1'b0, '0, '0, '0);
    push_req(REQ_MEASURE, 1'b0, 12'd4095, 12'd4095, 4'hF);
    push_req(REQ_MEASURE, 1'b1, 12'd300, 12'd300, 4'h0);
    push_req(REQ_READ, 1'b0, '0, '0, '0);
    push_req(REQ_READ, 1'b1, 12'hFFF, 12'hFFF, 4'hF);
    push_req(REQ_MEASURE, 1'b1, 12'd100, 12'd100, 4'h0);
    push_req(REQ_MEASURE, 1'b1, 12'd100, 12'd200, 4'h0);
    push_req(REQ_MEASURE, 1'b1, 12'd200, 12'd200, 4'h0);
    push_req(REQ_MEASURE, 1'b0, 12'd0, 12'd0, 4'h0);
    push_req(REQ_MEASURE, 1'b1, 12'd210, 12'd210, 4'h0);
    push_req(REQ_MEASURE, 1'b0, 12'd0, 12'd0, 4'h0);
    push_req(REQ_READ, 1'b0, '0, '0, '0);
    push_req(REQ_READ, 1'b0, '0, '0, '0);
    wait_drained();

    // Small random thresholds; the long receiver hold-off falls in this phase.
    set_cfg($urandom_range(0, 40), $urandom_range(0, 40), 0);
    walk_span = 60;
    fill_random(600);
    wait_drained();

    // Zero thresholds with swapped axes: every pen-down with a good tag posts unless an up is still unread.
    set_cfg(0, 0, 1);
    walk_span = 20;
    fill_random(300);
    wait_drained();

    // Largest thresholds: nearly everything falls in the deadband.
    set_cfg(4095, 4095, 1);
    walk_span = 4095;
    fill_random(300);
    wait_drained();

    set_cfg($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 1));
    walk_span = 200;
    fill_random(300);
    wait_drained();

    // Last phase at full rate, with no idling on either side.
    set_cfg($urandom_range(0, 30), $urandom_range(0, 30), 1);
    idle_on = 1'b0;
    walk_span = 40;
    fill_random(300);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== touch_contact_tracker.f =====
src/tct_pkg.sv
src/tct_cfg_regs.sv
src/tct_core.sv
src/touch_contact_tracker.sv
src/tct_checker.sv
tb/tb.sv
